/* src/bmp_pkg.sv */
// Shared constants and modular arithmetic helpers for the binomial block.
package bmp_pkg;

  localparam int unsigned TableSizeDefault = 65536;
  localparam logic [29:0] PrimeMod = 30'd998244353;

  // Barrett constant: floor(2^60 / p)
  localparam logic [30:0] BarrettMu = 31'd1154949187;

  typedef logic [29:0] residue_t;

  // Reduce a product below p*p to its residue: Barrett estimate, then one fixup.
  function automatic residue_t mod_reduce(input logic [59:0] prod, input logic [30:0] q_est);
    logic [60:0] qp;
    logic [31:0] rem;
    begin
      qp  = {30'd0, q_est} * {31'd0, PrimeMod};
      // remainder after the estimate is below 3p, so 32 low bits hold it exactly
      rem = prod[31:0] - qp[31:0];
      if (rem >= {1'b0, PrimeMod, 1'b0})
        rem = rem - {1'b0, PrimeMod, 1'b0};
      else if (rem >= {2'b00, PrimeMod})
        rem = rem - {2'b00, PrimeMod};
      mod_reduce = rem[29:0];
    end
  endfunction

endpackage

/* src/bmp_modmul.sv */
// Pipelined modular multiplier mod p with a user tag, four pipeline stages.
module bmp_modmul
  import bmp_pkg::*;
#(
  parameter int unsigned TagWidth = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  residue_t            a,
  input  residue_t            b,
  input  logic [TagWidth-1:0] in_tag,
  output logic                out_valid,
  output residue_t            product,
  output logic [TagWidth-1:0] out_tag
);

  logic [59:0] prod1, prod2, prod3;
  logic [61:0] mu_prod;
  logic [30:0] q_est;
  logic [3:0]  vld;
  logic [TagWidth-1:0] tag1, tag2, tag3, tag4;
  residue_t    res4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1   <= {30'd0, a} * {30'd0, b};
      tag1    <= in_tag;
      mu_prod <= {31'd0, prod1[59:29]} * {31'd0, BarrettMu};
      prod2   <= prod1;
      tag2    <= tag1;
      q_est   <= mu_prod[61:31];
      prod3   <= prod2;
      tag3    <= tag2;
      res4    <= mod_reduce(prod3, q_est);
      tag4    <= tag3;
    end
  end

  assign out_valid = vld[3];
  assign product   = res4;
  assign out_tag   = tag4;

endmodule

/* src/binomial_mod_prime.sv */
// Top level: factorial table builder, memory and query pipeline.
// Answers C(n,r) mod 998244353, one result word per query. After reset the block
// fills a table of i! mod p, one entry per modular multiply; each multiply passes
// through the four-stage multiplier before the next is issued. It then raises
// (TABLE_SIZE-1)! to p-2 (60 multiplies) and sweeps backward with TABLE_SIZE-1
// multiplies to fill a second table of inverse factorials, and no query is accepted
// until the build ends. Queries then flow one per cycle while the output is not
// stalled: each reads n!, (r!)^-1 and ((n-r)!)^-1 and passes two pipelined
// multiplies, and its result word is registered after them. A result word held by
// the receiver stalls the pipeline and the input. If r > n or n is beyond the table,
// the coefficient is 0 and invalid is set.
module binomial_mod_prime
  import bmp_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = TableSizeDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid_in,
  output logic        ready_in,
  input  logic [15:0] total_count,
  input  logic [15:0] chosen_count,
  output logic        valid_out,
  input  logic        ready_out,
  output logic [29:0] coefficient,
  output logic        invalid
);

  localparam int unsigned Aw = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  typedef enum logic [2:0] {S_FACT, S_EXP, S_INV, S_RUN} phase_t;
  phase_t phase;

  residue_t fact_mem [TABLE_SIZE];
  residue_t ifact_mem [TABLE_SIZE];

  // build multiplier, tag carries the table write address
  logic        m_en, m_iv, m_ov;
  residue_t    m_a, m_b, m_p;
  logic [Aw-1:0] m_itag, m_otag;

  // build control
  logic [Aw:0]  idx;
  residue_t     acc;
  residue_t     base;
  logic [4:0]   ebit;
  logic         busy;
  logic         sq_phase;

  localparam logic [29:0] ExpP2 = 30'd998244351;

  // query pipeline: stage q0 read, then two multiplies
  logic          q_stall;
  logic          bad0;
  residue_t      rd_n, rd_r, rd_nr;
  logic          mul1_v, mul2_v;

  assign q_stall = (phase == S_RUN) && valid_out && !ready_out;
  assign m_en = !q_stall;

  logic acc_in;
  assign ready_in = (phase == S_RUN) && !q_stall;
  assign acc_in = valid_in && ready_in;

  // table reads: one fact port and two inverse ports
  logic [Aw-1:0] ra_n, ra_r, ra_nr;
  logic          bad_c;
  assign bad_c = (chosen_count > total_count) ||
                 ({16'd0, total_count} >= 32'(TABLE_SIZE));
  assign ra_n  = Aw'(total_count);
  assign ra_r  = Aw'(chosen_count);
  assign ra_nr = Aw'(total_count - chosen_count);

  logic v0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (m_en) v0 <= acc_in;
  end
  always_ff @(posedge clk) begin
    if (m_en) begin
      rd_n  <= fact_mem[ra_n];
      rd_r  <= ifact_mem[ra_r];
      rd_nr <= ifact_mem[ra_nr];
      bad0  <= bad_c;
    end
  end

  // queries use dedicated multipliers; (n-r)! inverse and the bad flag ride as tag
  residue_t p1, p2;
  logic [30:0] t1out;
  bmp_modmul #(.TagWidth(31)) u_mul1 (
    .clk(clk), .rst(rst), .en(m_en), .in_valid(v0), .a(rd_n), .b(rd_r),
    .in_tag({bad0, rd_nr}), .out_valid(mul1_v), .product(p1), .out_tag(t1out));
  logic [0:0] b2;
  bmp_modmul #(.TagWidth(1)) u_mul2 (
    .clk(clk), .rst(rst), .en(m_en), .in_valid(mul1_v), .a(p1), .b(t1out[29:0]),
    .in_tag(t1out[30]), .out_valid(mul2_v), .product(p2), .out_tag(b2));

  always_ff @(posedge clk) begin
    if (rst) valid_out <= 1'b0;
    else if (m_en) valid_out <= mul2_v;
  end
  always_ff @(posedge clk) begin
    if (m_en) begin
      coefficient <= b2[0] ? '0 : p2;
      invalid     <= b2[0];
    end
  end

  // build engine
  bmp_modmul #(.TagWidth(Aw)) u_mulb (
    .clk(clk), .rst(rst), .en(1'b1), .in_valid(m_iv), .a(m_a), .b(m_b),
    .in_tag(m_itag), .out_valid(m_ov), .product(m_p), .out_tag(m_otag));

  always_comb begin
    m_iv = 1'b0; m_a = acc; m_b = base; m_itag = '0;
    unique case (phase)
      S_FACT: begin
        m_iv = !busy && (idx < (Aw+1)'(TABLE_SIZE));
        m_a = acc; m_b = residue_t'(idx); m_itag = Aw'(idx);
      end
      S_EXP: begin
        m_iv = !busy;
        m_a = sq_phase ? base : acc;
        m_b = base;
      end
      S_INV: begin
        m_iv = !busy && (idx != '0);
        m_a = acc; m_b = residue_t'(idx); m_itag = Aw'(idx - 1'b1);
      end
      default: m_iv = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= S_FACT; idx <= (Aw+1)'(1); acc <= 30'd1; busy <= 1'b0;
      ebit <= '0; sq_phase <= 1'b0; base <= '0;
    end else begin
      unique case (phase)
        S_FACT: begin
          if (m_iv) busy <= 1'b1;
          if (m_ov) begin
            busy <= 1'b0; acc <= m_p; idx <= idx + 1'b1;
            if (idx == (Aw+1)'(TABLE_SIZE - 1)) begin
              phase <= S_EXP; base <= m_p; acc <= 30'd1; ebit <= '0; sq_phase <= 1'b0;
            end
          end
        end
        S_EXP: begin
          if (m_iv) busy <= 1'b1;
          if (m_ov) begin
            busy <= 1'b0;
            if (!sq_phase) begin
              if (ExpP2[ebit]) acc <= m_p;
              sq_phase <= 1'b1;
            end else begin
              base <= m_p; sq_phase <= 1'b0;
              if (ebit == 5'd29) begin
                phase <= S_INV; idx <= (Aw+1)'(TABLE_SIZE - 1);
              end else ebit <= ebit + 1'b1;
            end
          end
        end
        S_INV: begin
          if (m_iv) busy <= 1'b1;
          if (idx == '0) phase <= S_RUN;
          if (m_ov) begin
            busy <= 1'b0; acc <= m_p; idx <= idx - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // table writes
  always_ff @(posedge clk) begin
    if (rst) fact_mem[0] <= 30'd1;
    else if (phase == S_FACT && m_ov) fact_mem[m_otag] <= m_p;
  end
  always_ff @(posedge clk) begin
    if (phase == S_INV && (idx == (Aw+1)'(TABLE_SIZE - 1)) && !busy && !m_ov) begin
      ifact_mem[idx[Aw-1:0]] <= acc;
    end else if (phase == S_INV && m_ov) begin
      ifact_mem[m_otag] <= m_p;
    end
  end

endmodule
